### sv/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and codes for the stack with positional insert.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 7;
  localparam int WORD_W = 64;
  localparam int FILL_W = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;      // capture position and word, shift pointer from fill
    logic    push_in;   // write input word on top, fill up
    logic    pop_rd;    // read top entry
    logic    pop_fin;   // fill down, return the read word
    logic    sh_rd;     // read entry below the shift pointer
    logic    sh_wr;     // write read word at the shift pointer, pointer down
    logic    ins_fin;   // write captured word at captured slot, fill up
    logic    respond;   // report code without changing state
    status_t code;
  } cmd_t;

  // flags from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic range_bad;
    logic at_top;
    logic sh_last;
  } stat_t;

endpackage

### sv/lsi_ctrl.sv
// ----------------------------------------------------------------------------
// lsi_ctrl
// Request sequencer: decodes an item and steps the datapath through it.
// ----------------------------------------------------------------------------
module lsi_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lsi_pkg::KIND_W-1:0]    kind,
  input  lsi_pkg::stat_t                stat,
  output lsi_pkg::cmd_t                 cmd,
  output logic                          busy
);
  import lsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SH_RD,
    S_SH_WR,
    S_INS
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_PUSH: begin
              if (stat.full) begin
                cmd.respond = 1'b1;
                cmd.code    = ST_FULL;
              end else begin
                cmd.push_in = 1'b1;
              end
            end
            KIND_POP: begin
              if (stat.empty) begin
                cmd.respond = 1'b1;
                cmd.code    = ST_EMPTY;
              end else begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP;
              end
            end
            KIND_INSERT: begin
              if (stat.range_bad) begin
                cmd.respond = 1'b1;
                cmd.code    = ST_RANGE;
              end else if (stat.full) begin
                cmd.respond = 1'b1;
                cmd.code    = ST_FULL;
              end else if (stat.at_top) begin
                cmd.push_in = 1'b1;
              end else begin
                cmd.load   = 1'b1;
                state_next = S_SH_RD;
              end
            end
            default: begin
              // unused kind: report ok, nothing changes
              cmd.respond = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_fin = 1'b1;
        state_next  = S_IDLE;
      end
      S_SH_RD: begin
        cmd.sh_rd  = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = stat.sh_last ? S_INS : S_SH_RD;
      end
      S_INS: begin
        cmd.ins_fin = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/lsi_dpath.sv
// ----------------------------------------------------------------------------
// lsi_dpath
// Entry memory, fill counter, shift pointer and result registers.
// ----------------------------------------------------------------------------
module lsi_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lsi_pkg::POS_W-1:0]     position,
  input  logic [lsi_pkg::WORD_W-1:0]    word_in,
  input  lsi_pkg::cmd_t                 cmd,
  output lsi_pkg::stat_t                stat,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [lsi_pkg::WORD_W-1:0]    word_out,
  output logic [lsi_pkg::FILL_W-1:0]    fill
);
  import lsi_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > POS_W) ? ((CW > FILL_W) ? CW : FILL_W)
                                   : ((POS_W > FILL_W) ? POS_W : FILL_W);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     ptr;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     posq_x;
  logic [XW-1:0]     count_x;
  logic [XW-1:0]     ptr_x;
  logic [XW-1:0]     fill_x;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     ptr_m1;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  assign pos_x    = XW'(position);
  assign posq_x   = XW'(pos_q);
  assign count_x  = XW'(count);
  assign ptr_x    = XW'(ptr);
  assign count_m1 = count - 1'b1;
  assign ptr_m1   = ptr - 1'b1;

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.range_bad = (pos_x > count_x);
  assign stat.at_top    = (pos_x == count_x);
  // the write in progress is the last shift once the pointer sits just above the slot
  assign stat.sh_last   = (ptr_x == posq_x + 1'b1);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = word_in;
    if (cmd.push_in) begin
      we = 1'b1;
    end else if (cmd.sh_wr) begin
      we    = 1'b1;
      waddr = ptr[AW-1:0];
      wdata = rdata;
    end else if (cmd.ins_fin) begin
      we    = 1'b1;
      waddr = posq_x[AW-1:0];
      wdata = word_q;
    end
  end

  assign re    = cmd.pop_rd | cmd.sh_rd;
  assign raddr = cmd.sh_rd ? ptr_m1[AW-1:0] : count_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.push_in || cmd.ins_fin) begin
      count_next = count + 1'b1;
    end else if (cmd.pop_fin) begin
      count_next = count_m1;
    end
  end

  assign fill_x = XW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.respond | cmd.push_in | cmd.pop_fin | cmd.ins_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_q  <= position;
      word_q <= word_in;
      ptr    <= count;
    end else if (cmd.sh_wr) begin
      ptr <= ptr_m1;
    end
    status   <= cmd.respond ? cmd.code : ST_OK;
    word_out <= cmd.pop_fin ? rdata : '0;
    fill     <= fill_x[FILL_W-1:0];
  end

endmodule

### sv/lifo_stack_with_insert_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_insert_top
// Bounded stack of 64-bit words with push, pop and insert at a slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on status, word_out and fill for one cycle with done high, and
// must be captured then. A push, an insert at the top slot, a failed request
// or an unused kind gives its result the cycle after it is taken and never
// raises busy. A pop reads the top entry, then returns it. An insert below
// the top moves each entry above the slot up by a read followed by a write,
// then writes the word into the slot; entries live in a memory with one read
// and one write port. Entries need no clearing after reset.
module lifo_stack_with_insert_top #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lsi_pkg::KIND_W-1:0]    kind,
  input  logic [lsi_pkg::POS_W-1:0]     position,
  input  logic [lsi_pkg::WORD_W-1:0]    word_in,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [lsi_pkg::WORD_W-1:0]    word_out,
  output logic [lsi_pkg::FILL_W-1:0]    fill
);
  import lsi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lsi_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .position (position),
    .word_in  (word_in),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .status   (status),
    .word_out (word_out),
    .fill     (fill)
  );

endmodule
